/* design/egbm_pkg.sv */
// ----------------------------------------------------------------------------
// egbm_pkg
// Shared constants, codes and controller/datapath interface types for the
// grid mean-elevation binning block.
// ----------------------------------------------------------------------------
`default_nettype none

package egbm_pkg;

   localparam int GRID_WIDTH_DEF  = 64;
   localparam int GRID_HEIGHT_DEF = 64;
   localparam int COUNT_BITS_DEF  = 16;

   localparam logic [15:0] RECIP_RESET = 16'd2560;
   localparam logic [9:0]  SCALE_RESET = 10'd100;

   localparam logic [1:0] CSR_RECIP = 2'd0;
   localparam logic [1:0] CSR_SCALE = 2'd1;

   localparam logic KIND_COMMIT = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   typedef enum logic [1:0] {
      ACT_ADD    = 2'd0,
      ACT_COMMIT = 2'd1,
      ACT_READ   = 2'd2
   } action_type;

   typedef enum logic [3:0] {
      S_CLR,
      S_IDLE,
      S_ADD_MUL,
      S_ADD_IDX,
      S_ADD_RD,
      S_ADD_WR,
      S_RD_RD,
      S_RD_OUT,
      S_CM_RD,
      S_CM_CHK,
      S_CM_DIV,
      S_CM_OUT
   } state_type;

   typedef struct packed {
      logic capture;
      logic mul_en;
      logic idx_en;
      logic sweep_mode;
      logic acc_wr;
      logic clr_wr;
      logic map_wr;
      logic map_zero;
      logic sweep_inc;
      logic div_start;
      logic upd_inc;
      logic rsp_commit;
      logic rsp_read;
   } cmd_type;

   typedef struct packed {
      logic sweep_last;
      logic cnt_ge2;
      logic div_done;
      logic rsp_busy;
   } sts_type;

endpackage

`default_nettype wire

/* design/egbm_div.sv */
// ----------------------------------------------------------------------------
// egbm_div
// Sequential divider: trunc(sum / (count * 256)) saturated to a signed byte.
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module egbm_div #(
   parameter int COUNT_BITS = egbm_pkg::COUNT_BITS_DEF
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         start,
   input  wire signed [COUNT_BITS+25:0] sum,
   input  wire        [COUNT_BITS-1:0] count,
   output logic                        done,
   output logic signed [7:0]           quot
);

   localparam int SB = COUNT_BITS + 26;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [2:0]    step_ff, step_in;
   logic [SB-1:0] rem_ff, rem_in;
   logic [SB-1:0] dv_ff, dv_in;
   logic [8:0]    q_ff, q_in;
   logic          neg_ff, neg_in;
   logic [SB-1:0] mag;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dv_in   = dv_ff;
      q_in    = q_ff;
      neg_in  = neg_ff;
      mag     = sum[SB-1] ? SB'(-sum) : SB'(sum);
      if (start) begin
         neg_in = sum[SB-1];
         if (mag >= (SB'(count) << 16)) begin
            q_in    = 9'd256;   // quotient beyond a byte
            done_in = 1'b1;
         end else begin
            rem_in  = mag;
            dv_in   = SB'(count) << 15;
            q_in    = 9'd0;
            step_in = 3'd7;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (rem_ff >= dv_ff) begin
            rem_in = rem_ff - dv_ff;
            q_in   = q_ff | (9'd1 << step_ff);
         end
         dv_in   = dv_ff >> 1;
         step_in = step_ff - 3'd1;
         if (step_ff == 3'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      dv_ff   <= dv_in;
      q_ff    <= q_in;
      neg_ff  <= neg_in;
   end

   always_comb begin
      if (neg_ff) begin
         quot = (q_ff > 9'd128) ? -8'sd128 : $signed(8'(9'd0 - q_ff));
      end else begin
         quot = (q_ff > 9'd127) ? 8'sd127 : $signed(q_ff[7:0]);
      end
   end

   assign done = done_ff;

endmodule

`default_nettype wire

/* design/egbm_dp.sv */
// ----------------------------------------------------------------------------
// egbm_dp
// Datapath: config registers, cell mapping, sum/count/map memories, sweep
// counter, divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module egbm_dp #(
   parameter int GRID_WIDTH  = egbm_pkg::GRID_WIDTH_DEF,
   parameter int GRID_HEIGHT = egbm_pkg::GRID_HEIGHT_DEF,
   parameter int COUNT_BITS  = egbm_pkg::COUNT_BITS_DEF
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 csr_we,
   input  wire  [1:0]          csr_index,
   input  wire  [15:0]         csr_wdata,
   input  wire  signed [15:0]  req_point_x,
   input  wire  signed [15:0]  req_point_y,
   input  wire  signed [15:0]  req_point_z,
   input  wire  [11:0]         req_read_index,
   input  wire                 rsp_ready,
   output logic                rsp_valid,
   output logic                rsp_result_kind,
   output logic signed [7:0]   rsp_cell_elevation,
   output logic [12:0]         rsp_cells_updated,
   input  egbm_pkg::cmd_type   cmd,
   output egbm_pkg::sts_type   sts
);

   localparam int CELLS     = GRID_WIDTH * GRID_HEIGHT;
   localparam int CELL_BITS = $clog2(CELLS);
   localparam int SUM_BITS  = COUNT_BITS + 26;

   logic [15:0] recip_ff;
   logic [9:0]  scale_ff;

   logic signed [15:0]    x_ff, y_ff, z_ff;
   logic [CELL_BITS-1:0]  ridx_ff;
   logic                  rin_ff;
   logic signed [33:0]    px_ff, py_ff;
   logic signed [26:0]    zs_ff;
   logic [CELL_BITS-1:0]  idx_ff, idx_in;
   logic [CELL_BITS-1:0]  sweep_ff, sweep_in;
   logic [12:0]           upd_ff, upd_in;

   logic signed [SUM_BITS-1:0] sum_mem [CELLS];
   logic [COUNT_BITS-1:0]      cnt_mem [CELLS];
   logic signed [7:0]          map_mem [CELLS];

   logic signed [SUM_BITS-1:0] sum_rd_ff, sum_wdata;
   logic [COUNT_BITS-1:0]      cnt_rd_ff, cnt_wdata;
   logic signed [7:0]          map_rd_ff, map_wdata;
   logic [CELL_BITS-1:0]       addr;
   logic                       cnt_full, sc_wr;

   logic                 div_done;
   logic signed [7:0]    div_q;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_kind_ff;
   logic signed [7:0]    rsp_elev_ff;
   logic [12:0]          rsp_upd_ff;

   // truncate toward zero, clamp to [0, lim-1]
   function automatic logic [31:0] clamp_cell(input logic signed [33:0] p,
                                              input logic [31:0] lim);
      logic [31:0] c;
      c = 32'(p[33:16]);
      if (p <= 34'sd0) begin
         return 32'd0;
      end
      if (c > lim - 32'd1) begin
         return lim - 32'd1;
      end
      return c;
   endfunction

   // config
   always_ff @(posedge clock) begin
      if (reset) begin
         recip_ff <= egbm_pkg::RECIP_RESET;
         scale_ff <= egbm_pkg::SCALE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            egbm_pkg::CSR_RECIP: recip_ff <= csr_wdata;
            egbm_pkg::CSR_SCALE: scale_ff <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   // item capture and point mapping
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff    <= req_point_x;
         y_ff    <= req_point_y;
         z_ff    <= req_point_z;
         ridx_ff <= CELL_BITS'(32'(req_read_index));
         rin_ff  <= 32'(req_read_index) < 32'(CELLS);
      end
      if (cmd.mul_en) begin
         px_ff <= x_ff * $signed({1'b0, recip_ff});
         py_ff <= y_ff * $signed({1'b0, recip_ff});
         zs_ff <= z_ff * $signed({1'b0, scale_ff});
      end
      if (cmd.idx_en) begin
         idx_ff <= idx_in;
      end
   end

   assign idx_in = CELL_BITS'(clamp_cell(py_ff, 32'(GRID_HEIGHT)) * 32'(GRID_WIDTH)
                              + clamp_cell(px_ff, 32'(GRID_WIDTH)));

   // sweep counter and commit tally
   always_comb begin
      sweep_in = sweep_ff;
      if (cmd.sweep_inc) begin
         sweep_in = sts.sweep_last ? '0 : sweep_ff + CELL_BITS'(1);
      end
      upd_in = upd_ff;
      if (cmd.capture) begin
         upd_in = '0;
      end else if (cmd.upd_inc) begin
         upd_in = upd_ff + 13'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
         upd_ff   <= '0;
      end else begin
         sweep_ff <= sweep_in;
         upd_ff   <= upd_in;
      end
   end

   // sum and count stores
   assign addr      = cmd.sweep_mode ? sweep_ff : idx_ff;
   assign cnt_full  = &cnt_rd_ff;
   assign sc_wr     = (cmd.acc_wr && !cnt_full) || cmd.clr_wr;
   assign sum_wdata = cmd.acc_wr ? sum_rd_ff + {{(SUM_BITS-27){zs_ff[26]}}, zs_ff} : '0;
   assign cnt_wdata = cmd.acc_wr ? cnt_rd_ff + COUNT_BITS'(1) : '0;

   always_ff @(posedge clock) begin
      if (sc_wr) begin
         sum_mem[addr] <= sum_wdata;
      end
      sum_rd_ff <= sum_mem[addr];
   end

   always_ff @(posedge clock) begin
      if (sc_wr) begin
         cnt_mem[addr] <= cnt_wdata;
      end
      cnt_rd_ff <= cnt_mem[addr];
   end

   // map store: written by the sweep, read by read items
   assign map_wdata = cmd.map_zero ? 8'sd0 : div_q;

   always_ff @(posedge clock) begin
      if (cmd.map_wr) begin
         map_mem[sweep_ff] <= map_wdata;
      end
      map_rd_ff <= map_mem[ridx_ff];
   end

   egbm_div #(
      .COUNT_BITS (COUNT_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .sum   (sum_rd_ff),
      .count (cnt_rd_ff),
      .done  (div_done),
      .quot  (div_q)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_commit || cmd.rsp_read) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.rsp_commit) begin
         rsp_kind_ff <= egbm_pkg::KIND_COMMIT;
         rsp_elev_ff <= 8'sd0;
         rsp_upd_ff  <= upd_ff;
      end else if (cmd.rsp_read) begin
         rsp_kind_ff <= egbm_pkg::KIND_READ;
         rsp_elev_ff <= rin_ff ? map_rd_ff : 8'sd0;
         rsp_upd_ff  <= 13'd0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_kind    = rsp_kind_ff;
   assign rsp_cell_elevation = rsp_elev_ff;
   assign rsp_cells_updated  = rsp_upd_ff;

   assign sts.sweep_last = (sweep_ff == CELL_BITS'(CELLS - 1));
   assign sts.cnt_ge2    = (cnt_rd_ff >= COUNT_BITS'(2));
   assign sts.div_done   = div_done;
   assign sts.rsp_busy   = rsp_valid_ff && !rsp_ready;

endmodule

`default_nettype wire

/* design/egbm_ctrl.sv */
// ----------------------------------------------------------------------------
// egbm_ctrl
// Controller: sequences add, read, commit sweep and the post-reset clear.
// ----------------------------------------------------------------------------
`default_nettype none

module egbm_ctrl (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  wire  [1:0]         req_action,
   input  egbm_pkg::sts_type  sts,
   output egbm_pkg::cmd_type  cmd
);

   egbm_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= egbm_pkg::S_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         egbm_pkg::S_CLR: begin
            cmd.sweep_mode = 1'b1;
            cmd.clr_wr     = 1'b1;
            cmd.map_wr     = 1'b1;
            cmd.map_zero   = 1'b1;
            cmd.sweep_inc  = 1'b1;
            if (sts.sweep_last) begin
               state_in = egbm_pkg::S_IDLE;
            end
         end
         egbm_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               case (egbm_pkg::action_type'(req_action))
                  egbm_pkg::ACT_ADD:    state_in = egbm_pkg::S_ADD_MUL;
                  egbm_pkg::ACT_COMMIT: state_in = egbm_pkg::S_CM_RD;
                  egbm_pkg::ACT_READ:   state_in = egbm_pkg::S_RD_RD;
                  default:              state_in = egbm_pkg::S_IDLE;
               endcase
            end
         end
         egbm_pkg::S_ADD_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = egbm_pkg::S_ADD_IDX;
         end
         egbm_pkg::S_ADD_IDX: begin
            cmd.idx_en = 1'b1;
            state_in   = egbm_pkg::S_ADD_RD;
         end
         egbm_pkg::S_ADD_RD: begin
            state_in = egbm_pkg::S_ADD_WR;
         end
         egbm_pkg::S_ADD_WR: begin
            cmd.acc_wr = 1'b1;
            state_in   = egbm_pkg::S_IDLE;
         end
         egbm_pkg::S_RD_RD: begin
            state_in = egbm_pkg::S_RD_OUT;
         end
         egbm_pkg::S_RD_OUT: begin
            if (!sts.rsp_busy) begin
               cmd.rsp_read = 1'b1;
               state_in     = egbm_pkg::S_IDLE;
            end
         end
         egbm_pkg::S_CM_RD: begin
            cmd.sweep_mode = 1'b1;
            state_in       = egbm_pkg::S_CM_CHK;
         end
         egbm_pkg::S_CM_CHK: begin
            cmd.sweep_mode = 1'b1;
            cmd.clr_wr     = 1'b1;
            if (sts.cnt_ge2) begin
               cmd.div_start = 1'b1;
               state_in      = egbm_pkg::S_CM_DIV;
            end else begin
               cmd.sweep_inc = 1'b1;
               state_in = sts.sweep_last ? egbm_pkg::S_CM_OUT : egbm_pkg::S_CM_RD;
            end
         end
         egbm_pkg::S_CM_DIV: begin
            cmd.sweep_mode = 1'b1;
            if (sts.div_done) begin
               cmd.map_wr    = 1'b1;
               cmd.upd_inc   = 1'b1;
               cmd.sweep_inc = 1'b1;
               state_in = sts.sweep_last ? egbm_pkg::S_CM_OUT : egbm_pkg::S_CM_RD;
            end
         end
         egbm_pkg::S_CM_OUT: begin
            if (!sts.rsp_busy) begin
               cmd.rsp_commit = 1'b1;
               state_in       = egbm_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = egbm_pkg::S_IDLE;
         end
      endcase
   end

   // divider finishes only while the sweep waits on it
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      sts.div_done |-> state_ff == egbm_pkg::S_CM_DIV)
      else $error("divider done outside divide wait");

   // a divide is started only for a cell holding two or more points
   a_div_start_cnt: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> sts.cnt_ge2)
      else $error("divide started on a sparse cell");

   // accumulate write follows its memory read cycle
   a_add_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == egbm_pkg::S_ADD_WR |-> $past(state_ff) == egbm_pkg::S_ADD_RD)
      else $error("accumulate without fresh read data");

endmodule

`default_nettype wire

/* design/elevation_grid_binning_mean.sv */
// ----------------------------------------------------------------------------
// elevation_grid_binning_mean
// Bins points into a grid of per-cell elevation sums and counts; a commit
// turns cells with two or more points into mean map values.
// ----------------------------------------------------------------------------
// Add point: capture, multiply, index, memory read, then accumulate write.
// Read: registered map read, then the result register once it is free.
// Commit: sweeps all cells; each cell is read and checked, and one with two or
//   more points also waits on the bit-serial divider (done early when the mean
//   is out of byte range); the result is loaded after the sweep.
// Reset: a clearing pass over every cell zeroes all stores;
//   req_ready stays low until it completes. Config is writable throughout.
// ----------------------------------------------------------------------------
`default_nettype none

module elevation_grid_binning_mean #(
   parameter int GRID_WIDTH  = egbm_pkg::GRID_WIDTH_DEF,
   parameter int GRID_HEIGHT = egbm_pkg::GRID_HEIGHT_DEF,
   parameter int COUNT_BITS  = egbm_pkg::COUNT_BITS_DEF
) (
   input  wire                clock,
   input  wire                reset,
   // configuration
   input  wire                csr_we,
   input  wire  [1:0]         csr_index,
   input  wire  [15:0]        csr_wdata,
   // point / command items
   input  wire                req_valid,
   output logic               req_ready,
   input  wire  [1:0]         req_action,
   input  wire  signed [15:0] req_point_x,
   input  wire  signed [15:0] req_point_y,
   input  wire  signed [15:0] req_point_z,
   input  wire  [11:0]        req_read_index,
   // result items
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output logic               rsp_result_kind,
   output logic signed [7:0]  rsp_cell_elevation,
   output logic [12:0]        rsp_cells_updated
);

   // commands and status between sequencer and datapath
   egbm_pkg::cmd_type cmd;
   egbm_pkg::sts_type sts;

   // sequencer: one item in flight; a pending result does not block accept
   egbm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .sts        (sts),
      .cmd        (cmd)
   );

   // datapath: sum/count/map memories, sweep counter, divider, result reg
   egbm_dp #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT),
      .COUNT_BITS  (COUNT_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_point_x        (req_point_x),
      .req_point_y        (req_point_y),
      .req_point_z        (req_point_z),
      .req_read_index     (req_read_index),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_cell_elevation (rsp_cell_elevation),
      .rsp_cells_updated  (rsp_cells_updated),
      .cmd                (cmd),
      .sts                (sts)
   );

endmodule

`default_nettype wire
